@@ rtl/core/gvsl_pkg.sv @@
// ============================================================================
// gvsl_pkg
// Shared widths, reset values, register indexes, controller states and the
// command/status bundles of the gated variable-step low-pass filter.
// ============================================================================
package gvsl_pkg;

	// Sample and level width.
	localparam int SAMPLE_BITS = 12;

	// Field and register widths.
	localparam int TIME_W    = 32;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 1;

	// Divider: the divisor tau + gap needs one bit more than the timestamp.
	localparam int DIV_W  = TIME_W + 1;
	localparam int KEEP_W = SAMPLE_BITS + CFG_W;
	localparam int TAKE_W = SAMPLE_BITS + TIME_W;
	localparam int STEP_W = $clog2(TAKE_W);

	// Stream payload widths, padded to whole bytes.
	localparam int IN_TDATA_W  = ((TIME_W + SAMPLE_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

	// Reset values.
	localparam logic [CFG_W-1:0]       TAU_RESET     = CFG_W'(250);
	localparam logic [CFG_W-1:0]       MIN_GAP_RESET = CFG_W'(25);
	localparam logic [SAMPLE_BITS-1:0] LEVEL_RESET   = SAMPLE_BITS'(2000);

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_TAU     = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP = CFG_IDX_W'(1);

	// Controller states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_GAP,
		ST_MUL,
		ST_LDK,
		ST_DIVK,
		ST_LDT,
		ST_DIVT,
		ST_SUM,
		ST_OUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic eval_gap;
		logic mul;
		logic load_keep;
		logic load_take;
		logic div_step;
		logic commit;
		logic load_out;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic upd;
		logic out_free;
	} status_t;

endpackage

@@ rtl/core/gvsl_dp.sv @@
// ============================================================================
// gvsl_dp
// Datapath: configuration registers, filter state, gap check, the two
// products, a shared restoring divider and the output register.
// ============================================================================
module gvsl_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  gvsl_pkg::cmd_t                      cmd,
	output gvsl_pkg::status_t                   sts,
	input  logic                                cfg_we,
	input  logic [gvsl_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gvsl_pkg::CFG_W-1:0]          cfg_data,
	input  logic [gvsl_pkg::IN_TDATA_W-1:0]     in_tdata,
	output logic                                out_tvalid,
	input  logic                                out_tready,
	output logic [gvsl_pkg::OUT_TDATA_W-1:0]    out_tdata,
	output logic                                out_tuser
);
	import gvsl_pkg::*;

	logic [CFG_W-1:0]       tau_q;
	logic [CFG_W-1:0]       min_gap_q;
	logic [SAMPLE_BITS-1:0] level_q;
	logic [TIME_W-1:0]      last_q;
	logic [TIME_W-1:0]      time_q;
	logic [SAMPLE_BITS-1:0] smp_q;
	logic [TIME_W-1:0]      gap_q;
	logic                   upd_q;
	logic [KEEP_W-1:0]      prod_k_q;
	logic [TAKE_W-1:0]      prod_t_q;
	logic [DIV_W-1:0]       div_q;
	logic [TAKE_W-1:0]      nq_q;
	logic [DIV_W-1:0]       rem_q;
	logic [SAMPLE_BITS-1:0] keep_q;
	logic [SAMPLE_BITS-1:0] out_level_q;
	logic                   out_upd_q;
	logic                   out_valid_q;

	logic [TIME_W-1:0]      gap;
	logic                   gap_over;
	logic [DIV_W:0]         shifted;
	logic [DIV_W:0]         diff;
	logic                   q_bit;
	logic [SAMPLE_BITS:0]   level_sum;

	// Modular gap since the last update.
	assign gap = time_q - last_q;

	// The filter updates only when the gap exceeds min_gap.
	assign gap_over = (gap > TIME_W'(min_gap_q));

	// One restoring division step: bring down the next numerator bit and
	// subtract the divisor when it fits.
	assign shifted = {rem_q, nq_q[TAKE_W-1]};
	assign diff    = shifted - {1'b0, div_q};
	assign q_bit   = ~diff[DIV_W];

	// Both floored terms together never exceed the level range.
	assign level_sum = {1'b0, keep_q} + {1'b0, nq_q[SAMPLE_BITS-1:0]};

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tau_q     <= TAU_RESET;
			min_gap_q <= MIN_GAP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TAU:     tau_q     <= cfg_data;
				REG_MIN_GAP: min_gap_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Filter state: level and time of the last update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= LEVEL_RESET;
			last_q  <= '0;
		end else if (cmd.commit) begin
			level_q <= level_sum[SAMPLE_BITS-1:0];
			last_q  <= time_q;
		end
	end

	// Working registers of the current beat.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			time_q <= in_tdata[TIME_W-1:0];
			smp_q  <= in_tdata[TIME_W+SAMPLE_BITS-1:TIME_W];
		end
		if (cmd.eval_gap) begin
			gap_q <= gap;
			upd_q <= gap_over;
		end
		if (cmd.mul) begin
			prod_k_q <= KEEP_W'(level_q) * KEEP_W'(tau_q);
			prod_t_q <= TAKE_W'(smp_q) * TAKE_W'(gap_q);
			div_q    <= DIV_W'(tau_q) + DIV_W'(gap_q);
		end
	end

	// Shared divider: the keep numerator is loaded at the top so that it
	// finishes in fewer steps; the take numerator uses the full width.
	always_ff @(posedge clk) begin
		if (cmd.load_keep) begin
			nq_q  <= {prod_k_q, {(TAKE_W-KEEP_W){1'b0}}};
			rem_q <= '0;
		end else if (cmd.load_take) begin
			keep_q <= nq_q[SAMPLE_BITS-1:0];
			nq_q   <= prod_t_q;
			rem_q  <= '0;
		end else if (cmd.div_step) begin
			nq_q  <= {nq_q[TAKE_W-2:0], q_bit};
			rem_q <= q_bit ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_level_q <= level_q;
			out_upd_q   <= upd_q;
		end
	end

	assign sts.upd      = gap_over;
	assign sts.out_free = ~out_valid_q | out_tready;

	assign out_tvalid = out_valid_q;
	assign out_tdata  = OUT_TDATA_W'(out_level_q);
	assign out_tuser  = out_upd_q;

endmodule

@@ rtl/core/gvsl_ctrl.sv @@
// ============================================================================
// gvsl_ctrl
// Controller: sequences gap check, products, the two divisions, the level
// update and the hand-off to the output register.
// ============================================================================
module gvsl_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_tvalid,
	output logic                in_tready,
	input  gvsl_pkg::status_t   sts,
	output gvsl_pkg::cmd_t      cmd
);
	import gvsl_pkg::*;

	state_t            state_q;
	state_t            state_nxt;
	logic [STEP_W-1:0] cnt_q;
	logic              cnt_done;

	assign cnt_done = (cnt_q == '0);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Division step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_q == ST_LDK) begin
			cnt_q <= STEP_W'(KEEP_W - 1);
		end else if (state_q == ST_LDT) begin
			cnt_q <= STEP_W'(TAKE_W - 1);
		end else if (!cnt_done) begin
			cnt_q <= cnt_q - STEP_W'(1);
		end
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: if (in_tvalid) state_nxt = ST_GAP;
			ST_GAP:  state_nxt = sts.upd ? ST_MUL : ST_OUT;
			ST_MUL:  state_nxt = ST_LDK;
			ST_LDK:  state_nxt = ST_DIVK;
			ST_DIVK: if (cnt_done) state_nxt = ST_LDT;
			ST_LDT:  state_nxt = ST_DIVT;
			ST_DIVT: if (cnt_done) state_nxt = ST_SUM;
			ST_SUM:  state_nxt = ST_OUT;
			ST_OUT:  if (sts.out_free) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		cmd       = '0;
		in_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_tready   = 1'b1;
				cmd.capture = in_tvalid;
			end
			ST_GAP:  cmd.eval_gap  = 1'b1;
			ST_MUL:  cmd.mul       = 1'b1;
			ST_LDK:  cmd.load_keep = 1'b1;
			ST_DIVK: cmd.div_step  = 1'b1;
			ST_LDT:  cmd.load_take = 1'b1;
			ST_DIVT: cmd.div_step  = 1'b1;
			ST_SUM:  cmd.commit    = 1'b1;
			ST_OUT:  cmd.load_out  = sts.out_free;
			default: ;
		endcase
	end

endmodule

@@ rtl/core/gated_variable_step_lowpass.sv @@
// ============================================================================
// gated_variable_step_lowpass
// First-order low-pass filter with a variable time step, updated only when
// the time since the last update exceeds a minimum gap.
// ============================================================================
// Usage:
// The input stream (s_*) carries one beat per ADC sample: a millisecond
// timestamp and the raw sample. The output stream (m_*) returns one beat per
// input beat: the filtered level in m_tdata and, in m_tuser, a flag that is
// set when the sample updated the filter.
// A beat whose gap does not exceed min_gap skips the products and the
// divider. An updating beat runs the two products and then both quotients
// on one shared restoring divider, one quotient bit per cycle: the level
// term takes SAMPLE_BITS+16 steps and the sample term SAMPLE_BITS+32.
// The next beat is taken only after the result enters the output register.
// The output register lets a new beat be accepted while the previous result
// still waits; if the receiver stalls, the finished result waits in the
// controller until the output register frees up.
// Reset sets tau to 250, min_gap to 25, the level to 2000 and the last
// update time to 0. tau and min_gap are written through cfg_we, cfg_index
// (0 for tau, 1 for min_gap) and cfg_data; the user must do so only while
// the block is idle, as the block itself does not enforce it.
// ============================================================================
module gated_variable_step_lowpass (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration write port.
	input  logic                                cfg_we,
	input  logic [gvsl_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gvsl_pkg::CFG_W-1:0]          cfg_data,
	// Input stream.
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [gvsl_pkg::IN_TDATA_W-1:0]     s_tdata,  // time_ms, sample_value
	// Output stream.
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [gvsl_pkg::OUT_TDATA_W-1:0]    m_tdata,  // level
	output logic                                m_tuser   // updated
);
	import gvsl_pkg::*;

	cmd_t    cmd;
	status_t sts;

	// Sequencer.
	gvsl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_tvalid (s_tvalid),
		.in_tready (s_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Arithmetic, state and output register.
	gvsl_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_tdata   (s_tdata),
		.out_tvalid (m_tvalid),
		.out_tready (m_tready),
		.out_tdata  (m_tdata),
		.out_tuser  (m_tuser)
	);

endmodule

@@ rtl/core/gvsl_chk.sv @@
// ============================================================================
// gvsl_chk
// Port-level checker for the gated variable-step low-pass filter, bound to
// the top level.
// ============================================================================
module gvsl_chk (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	input  logic                                s_tready,
	input  logic                                m_tvalid,
	input  logic                                m_tready,
	input  logic [gvsl_pkg::OUT_TDATA_W-1:0]    m_tdata,
	input  logic                                m_tuser
);
	import gvsl_pkg::*;

	// A stalled result beat stays valid.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output beat dropped while stalled");

	// A stalled result beat keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("output payload changed while stalled");

	// An accepted sample is worked on before the next one is taken.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted on back-to-back cycles");

	// A fresh result means the controller has gone back to waiting for input.
	a_ready_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> s_tready)
		else $error("result issued without returning to idle");

endmodule

bind gated_variable_step_lowpass gvsl_chk u_gvsl_chk (.*);

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the gated variable-step low-pass filter
// Sample beats are sent on the input stream and every output beat is checked
// against a predictor of the filter that tracks the level, the last update
// time and the two registers. A short directed part covers the gap gate,
// timestamp wraps, the register extremes and a tau of zero. Random traffic
// then runs under several register settings, with no idling, an idle
// sender, a stalling receiver, and both together.
// ----------------------------------------------------------------------------
module tb_top;
	import gvsl_pkg::*;

	localparam int CLK_HALF    = 5;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int PHASE_BEATS = 175;
	localparam int PAD_W       = IN_TDATA_W - TIME_W - SAMPLE_BITS;

	// One expected output beat.
	typedef struct packed {
		logic [SAMPLE_BITS-1:0] level;
		logic                   updated;
	} level_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = REG_TAU;
	logic [CFG_W-1:0]       cfg_data = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;  // time_ms, sample_value
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;       // level
	logic                   m_tuser;       // updated

	// Predictor state and its copy of the registers.
	logic [SAMPLE_BITS-1:0] model_level = LEVEL_RESET;
	logic [TIME_W-1:0]      model_last_time = '0;
	logic [CFG_W-1:0]       cfg_tau = TAU_RESET;
	logic [CFG_W-1:0]       cfg_min_gap = MIN_GAP_RESET;

	level_result_t expected_levels[$];
	int            fail_count = 0;
	int            cycle_count = 0;
	int            src_idle_pct = 0;
	int            sink_stall_pct = 0;

	gated_variable_step_lowpass dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	// Clock.
	always #CLK_HALF clk = ~clk;

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Receiver back-pressure.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
	end

	// Compare each output beat with the oldest expected result.
	always @(posedge clk) begin : check_results
		level_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_levels.size() == 0) begin
				$error("unexpected output beat: level %0d, updated %0d",
					m_tdata[SAMPLE_BITS-1:0], m_tuser);
				fail_count++;
			end else begin
				want = expected_levels.pop_front();
				if (m_tdata[SAMPLE_BITS-1:0] !== want.level) begin
					$error("level: expected %0d, got %0d", want.level,
						m_tdata[SAMPLE_BITS-1:0]);
					fail_count++;
				end
				if (m_tuser !== want.updated) begin
					$error("updated: expected %0d, got %0d", want.updated, m_tuser);
					fail_count++;
				end
			end
		end
	end

	// Gate on the modular gap, then blend level and sample with truncating
	// division by tau + gap, taken at 64 bits so the sum never wraps.
	function automatic level_result_t advance_filter(input logic [TIME_W-1:0] t,
			input logic [SAMPLE_BITS-1:0] s);
		logic [TIME_W-1:0] gap;
		logic [63:0]       lvl_w, smp_w, tau_w, gap_w, divisor, keep, take;
		level_result_t     res;
		gap = t - model_last_time;
		res.updated = 1'b0;
		if (gap > TIME_W'(cfg_min_gap)) begin
			lvl_w   = 64'(model_level);
			smp_w   = 64'(s);
			tau_w   = 64'(cfg_tau);
			gap_w   = 64'(gap);
			divisor = tau_w + gap_w;
			keep    = (lvl_w * tau_w) / divisor;
			take    = (smp_w * gap_w) / divisor;
			model_level     = SAMPLE_BITS'(keep + take);
			model_last_time = t;
			res.updated     = 1'b1;
		end
		res.level = model_level;
		return res;
	endfunction

	// Send one sample beat, after an optional idle gap, and record its result.
	task automatic send_sample(input logic [TIME_W-1:0] t, input logic [SAMPLE_BITS-1:0] s);
		int gap_cycles;
		gap_cycles = 0;
		if ($urandom_range(0, 99) < src_idle_pct)
			gap_cycles = $urandom_range(1, 100);
		if (gap_cycles > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap_cycles) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{PAD_W{1'b0}}, s, t};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		expected_levels.push_back(advance_filter(t, s));
	endtask

	// Stop sending and wait until every expected beat has come back.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_levels.size() != 0) @(posedge clk);
	endtask

	// Write both registers; only called while the filter is idle.
	task automatic write_registers(input logic [CFG_W-1:0] new_tau,
			input logic [CFG_W-1:0] new_min_gap);
		cfg_we    <= 1'b1;
		cfg_index <= REG_TAU;
		cfg_data  <= new_tau;
		@(posedge clk);
		cfg_index <= REG_MIN_GAP;
		cfg_data  <= new_min_gap;
		@(posedge clk);
		cfg_we      <= 1'b0;
		cfg_tau     = new_tau;
		cfg_min_gap = new_min_gap;
	endtask

	// Reset registers: gaps below, at and just above min_gap, a backwards
	// timestamp and a wrap through zero.
	task automatic test_gate_at_reset();
		send_sample(32'd0, 12'hFFF);
		send_sample(32'd25, 12'hFFF);
		send_sample(32'd26, 12'hFFF);
		send_sample(32'd51, 12'h000);
		send_sample(32'hFFFF_FFFF, 12'h000);
		send_sample(32'h0000_001A, 12'hFFF);
		drain_results();
	endtask

	// Largest tau and min_gap, the largest gap, then a tau of one and a min_gap of zero.
	task automatic test_register_extremes();
		write_registers(16'hFFFF, 16'hFFFF);
		send_sample(model_last_time + 32'd65535, 12'hFFF);
		send_sample(model_last_time + 32'd65536, 12'hFFF);
		send_sample(model_last_time - 32'd1, 12'hFFF);
		send_sample(model_last_time - 32'd1, 12'h000);
		drain_results();
		write_registers(16'd1, 16'd0);
		send_sample(model_last_time, 12'h000);
		send_sample(model_last_time + 32'd1, 12'h000);
		send_sample(model_last_time + 32'd1, 12'hFFF);
		send_sample(model_last_time + 32'd1, 12'h555);
		send_sample(model_last_time + 32'd2, 12'hAAA);
		drain_results();
	endtask

	// A tau of zero makes the new level equal to the sample.
	task automatic test_zero_tau();
		write_registers(16'd0, 16'd0);
		send_sample(model_last_time + 32'd1, 12'hABC);
		send_sample(model_last_time + 32'd5, 12'h000);
		send_sample(model_last_time + 32'd1, 12'hFFF);
		send_sample(model_last_time, 12'h123);
		drain_results();
	endtask

	// Random timestamps and samples over several settings and idling modes.
	task automatic test_random_traffic();
		logic [TIME_W-1:0]      t;
		logic [TIME_W-1:0]      gap;
		logic [TIME_W-1:0]      span;
		logic [SAMPLE_BITS-1:0] s;
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: write_registers(TAU_RESET, MIN_GAP_RESET);
				1: write_registers(16'd1, 16'd0);
				2: write_registers(16'hFFFF, 16'hFFFF);
				3: write_registers(16'($urandom_range(1, 65535)), 16'($urandom_range(0, 1000)));
				4: write_registers(16'($urandom_range(1, 2000)), 16'($urandom_range(0, 100)));
				5: write_registers(16'($urandom), 16'($urandom));
				6: write_registers(16'd0, 16'($urandom_range(0, 50)));
				default: write_registers(16'($urandom_range(1, 65535)), 16'($urandom_range(0, 300)));
			endcase
			case (phase % 4)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 68; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 68; end
				default: begin src_idle_pct = 34; sink_stall_pct = 34; end
			endcase
			span = TIME_W'(cfg_tau) * 4 + 8;
			for (int n = 0; n < PHASE_BEATS; n++) begin
				// Mostly updating gaps, with gated, boundary, backwards and
				// arbitrary timestamps mixed in.
				case ($urandom_range(0, 19))
					0, 1, 2: gap = $urandom_range(0, cfg_min_gap);
					3:       gap = TIME_W'(cfg_min_gap);
					4:       gap = TIME_W'(cfg_min_gap) + 1;
					5:       gap = 32'd0 - $urandom_range(1, 100000);
					6:       gap = $urandom;
					default: gap = TIME_W'(cfg_min_gap) + 1 + $urandom_range(0, span);
				endcase
				t = model_last_time + gap;
				case ($urandom_range(0, 9))
					0:       s = '0;
					1:       s = '1;
					default: s = SAMPLE_BITS'($urandom);
				endcase
				send_sample(t, s);
			end
			drain_results();
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_gate_at_reset();
		test_register_extremes();
		test_zero_tau();
		test_random_traffic();
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/gvsl_pkg.sv
rtl/core/gvsl_dp.sv
rtl/core/gvsl_ctrl.sv
rtl/core/gated_variable_step_lowpass.sv
rtl/core/gvsl_chk.sv
verif/tb_top.sv
